// ===== src/vfcv_pkg.sv =====
// ============================================================================
// vfcv_pkg
// Shared types, block codes and constant tables for the voxel face cull and
// vertex pack pipeline.
// ============================================================================
package vfcv_pkg;

  localparam int unsigned NUM_FACES = 6;
  localparam logic [2:0]  LAST_VERT = 3'd5;

  typedef enum logic [3:0] {
    BT_AIR       = 4'd0,
    BT_GRASS     = 4'd1,
    BT_DIRT      = 4'd2,
    BT_STONE     = 4'd3,
    BT_PLANT     = 4'd4,
    BT_OAK_LOG   = 4'd5,
    BT_OAK_LOG_X = 4'd6,
    BT_OAK_LOG_Z = 4'd7,
    BT_LEAVES    = 4'd8,
    BT_OUTLINE   = 4'd9,
    BT_NO_BLOCK  = 4'd10
  } block_t;

  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
  } voxel_pos_t;

  // One vertex request from the face sequencer to the vertex generator.
  typedef struct packed {
    logic       valid;
    logic [3:0] btype;
    logic [2:0] face;
    logic [2:0] vert;
    voxel_pos_t pos;
    logic       last;
  } vtx_req_t;

  // A face shape: light level and its four corners, each corner coded as
  // {x, y, z} with a set bit meaning pixel 32 and a clear bit pixel 16.
  typedef struct packed {
    logic [1:0]      light;
    logic [3:0][2:0] corner;
  } shape_t;

  typedef struct packed {
    logic [1:0] x;
    logic [3:0] y;
  } tex_corner_t;

  function automatic logic is_solid(input logic [3:0] t);
    logic s;
    unique case (t) inside
      BT_GRASS, BT_DIRT, BT_STONE, BT_OAK_LOG, BT_OAK_LOG_X, BT_OAK_LOG_Z,
      BT_LEAVES: s = 1'b1;
      default:   s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] face_count(input logic [3:0] t);
    logic [2:0] n;
    unique case (t) inside
      BT_PLANT: n = 3'd4;
      BT_GRASS, BT_DIRT, BT_STONE, BT_OAK_LOG, BT_OAK_LOG_X, BT_OAK_LOG_Z,
      BT_LEAVES, BT_OUTLINE: n = 3'd6;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // Faces that survive culling. Neighbour i is the one on the culling side
  // of face i for cube-shaped blocks.
  function automatic logic [NUM_FACES-1:0] face_mask(input logic [3:0] t,
                                                     input logic [NUM_FACES-1:0][3:0] nb);
    logic [NUM_FACES-1:0] m;
    logic [2:0]           cnt;
    logic                 culls;
    cnt   = face_count(t);
    culls = (t != BT_PLANT) && (t != BT_OUTLINE);
    for (int f = 0; f < NUM_FACES; f++) begin
      m[f] = (3'(f) < cnt) && (!culls || !is_solid(nb[f]));
    end
    return m;
  endfunction

  // Index of the lowest set bit; the mask is never empty when this is used.
  function automatic logic [2:0] first_face(input logic [NUM_FACES-1:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (m[f]) begin
        idx = 3'(f);
      end
    end
    return idx;
  endfunction

  function automatic logic [3:0] face_shape(input logic [3:0] t, input logic [2:0] face);
    logic [3:0] s;
    if (t == BT_PLANT) begin
      unique case (face)
        3'd0:    s = 4'd6;
        3'd1:    s = 4'd7;
        3'd2:    s = 4'd8;
        3'd3:    s = 4'd9;
        default: s = 4'd0;
      endcase
    end else begin
      s = {1'b0, face};
    end
    return s;
  endfunction

  function automatic logic [3:0] face_tex(input logic [3:0] t, input logic [2:0] face);
    logic [3:0] c;
    unique case (t) inside
      BT_GRASS:     c = (face == 3'd4) ? 4'd0 : (face == 3'd5) ? 4'd2 : 4'd1;
      BT_DIRT:      c = 4'd2;
      BT_STONE:     c = 4'd3;
      BT_PLANT:     c = (face < 3'd4) ? 4'd4 : 4'd0;
      BT_OAK_LOG:   c = (face < 3'd4) ? 4'd5 : 4'd6;
      BT_OAK_LOG_X: c = (face < 3'd2) ? 4'd6 : 4'd5;
      BT_OAK_LOG_Z: c = (face == 3'd2 || face == 3'd3) ? 4'd6 : 4'd5;
      BT_LEAVES:    c = 4'd7;
      BT_OUTLINE:   c = 4'd8;
      default:      c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic shape_t shape_entry(input logic [3:0] s);
    shape_t e;
    unique case (s)
      4'd0:    e = '{light: 2'd2, corner: {3'b111, 3'b110, 3'b100, 3'b101}};
      4'd1:    e = '{light: 2'd2, corner: {3'b010, 3'b011, 3'b001, 3'b000}};
      4'd2:    e = '{light: 2'd1, corner: {3'b011, 3'b111, 3'b101, 3'b001}};
      4'd3:    e = '{light: 2'd1, corner: {3'b110, 3'b010, 3'b000, 3'b100}};
      4'd4:    e = '{light: 2'd3, corner: {3'b010, 3'b110, 3'b111, 3'b011}};
      4'd5:    e = '{light: 2'd0, corner: {3'b001, 3'b101, 3'b100, 3'b000}};
      4'd6:    e = '{light: 2'd3, corner: {3'b010, 3'b111, 3'b101, 3'b000}};
      4'd7:    e = '{light: 2'd3, corner: {3'b111, 3'b010, 3'b000, 3'b101}};
      4'd8:    e = '{light: 2'd3, corner: {3'b011, 3'b110, 3'b100, 3'b001}};
      4'd9:    e = '{light: 2'd3, corner: {3'b110, 3'b011, 3'b001, 3'b100}};
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic tex_corner_t tex_corner(input logic [3:0] c);
    tex_corner_t r;
    unique case (c)
      4'd0:    r = '{x: 2'd2, y: 4'd15};
      4'd1:    r = '{x: 2'd0, y: 4'd15};
      4'd2:    r = '{x: 2'd1, y: 4'd15};
      4'd3:    r = '{x: 2'd3, y: 4'd15};
      4'd4:    r = '{x: 2'd0, y: 4'd13};
      4'd5:    r = '{x: 2'd0, y: 4'd14};
      4'd6:    r = '{x: 2'd1, y: 4'd14};
      4'd7:    r = '{x: 2'd2, y: 4'd14};
      4'd8:    r = '{x: 2'd1, y: 4'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // The six vertices of a face visit the corners as two triangles.
  function automatic logic [1:0] vert_corner(input logic [2:0] v);
    logic [1:0] c;
    unique case (v)
      3'd1:       c = 2'd1;
      3'd2, 3'd3: c = 2'd2;
      3'd4:       c = 2'd3;
      default:    c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] pixel(input logic hi);
    return hi ? 6'd32 : 6'd16;
  endfunction

endpackage

// ===== src/vfcv_face_seq.sv =====
// ============================================================================
// vfcv_face_seq
// Takes voxels, works out the surviving faces and issues one vertex request
// per cycle while en is high, walking kept faces in table order.
// ============================================================================
module vfcv_face_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           block_type,
  input  vfcv_pkg::voxel_pos_t pos,
  input  logic [vfcv_pkg::NUM_FACES-1:0][3:0] nb,
  output vfcv_pkg::vtx_req_t   req
);

  logic                          busy_r, busy_nxt;
  logic [3:0]                    type_r, type_nxt;
  vfcv_pkg::voxel_pos_t          pos_r, pos_nxt;
  logic [vfcv_pkg::NUM_FACES-1:0] mask_r, mask_nxt;
  logic [2:0]                    vert_r, vert_nxt;

  logic       last_face;
  logic       emit;
  logic       last_emit;
  logic       take;
  logic [vfcv_pkg::NUM_FACES-1:0] new_mask;

  assign last_face = (mask_r & (mask_r - 1'b1)) == '0;
  assign emit      = busy_r && en;
  assign last_emit = emit && (vert_r == vfcv_pkg::LAST_VERT) && last_face;
  assign in_stall  = busy_r && !last_emit;
  assign take      = in_valid && !in_stall;
  assign new_mask  = vfcv_pkg::face_mask(block_type, nb);

  always_comb begin
    busy_nxt = busy_r;
    type_nxt = type_r;
    pos_nxt  = pos_r;
    mask_nxt = mask_r;
    vert_nxt = vert_r;
    if (take) begin
      busy_nxt = |new_mask;
      type_nxt = block_type;
      pos_nxt  = pos;
      mask_nxt = new_mask;
      vert_nxt = 3'd0;
    end else if (emit) begin
      if (vert_r == vfcv_pkg::LAST_VERT) begin
        mask_nxt = mask_r & (mask_r - 1'b1);
        vert_nxt = 3'd0;
        busy_nxt = !last_face;
      end else begin
        vert_nxt = vert_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    type_r <= type_nxt;
    pos_r  <= pos_nxt;
    mask_r <= mask_nxt;
    vert_r <= vert_nxt;
  end

  always_comb begin
    req.valid = busy_r;
    req.btype = type_r;
    req.face  = vfcv_pkg::first_face(mask_r);
    req.vert  = vert_r;
    req.pos   = pos_r;
    req.last  = (vert_r == vfcv_pkg::LAST_VERT) && last_face;
  end

endmodule

// ===== src/vfcv_vertex_gen.sv =====
// ============================================================================
// vfcv_vertex_gen
// Two register stages: face table lookup, then shape and texture lookup with
// packing into the output register.
// ============================================================================
module vfcv_vertex_gen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  vfcv_pkg::vtx_req_t req,
  output logic               out_valid,
  output logic [15:0]        out_pos_word,
  output logic [15:0]        out_attr_word,
  output logic [15:0]        out_tex_word,
  output logic               out_last_vertex
);

  // Stage one: face tables.
  logic                 s1_valid_r;
  logic [3:0]           s1_shape_r;
  logic [3:0]           s1_tex_r;
  logic [2:0]           s1_vert_r;
  vfcv_pkg::voxel_pos_t s1_pos_r;
  logic                 s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= req.valid;
    end
    if (en) begin
      s1_shape_r <= vfcv_pkg::face_shape(req.btype, req.face);
      s1_tex_r   <= vfcv_pkg::face_tex(req.btype, req.face);
      s1_vert_r  <= req.vert;
      s1_pos_r   <= req.pos;
      s1_last_r  <= req.last;
    end
  end

  // Stage two: corner and texture lookup, then packing.
  vfcv_pkg::shape_t      sh;
  vfcv_pkg::tex_corner_t tc;
  logic [1:0]            cn;
  logic [2:0]            corner;
  logic [4:0]            x_tex, y_tex;
  logic [15:0]           attr_nxt, tex_nxt, pos_nxt;

  always_comb begin
    sh       = vfcv_pkg::shape_entry(s1_shape_r);
    tc       = vfcv_pkg::tex_corner(s1_tex_r);
    cn       = vfcv_pkg::vert_corner(s1_vert_r);
    corner   = sh.corner[cn];
    x_tex    = 5'(tc.x) + 5'((cn == 2'd1) || (cn == 2'd2));
    y_tex    = 5'(tc.y) + 5'((cn == 2'd2) || (cn == 2'd3));
    attr_nxt = {2'b00, sh.light, vfcv_pkg::pixel(corner[2]), vfcv_pkg::pixel(corner[1])};
    tex_nxt  = {vfcv_pkg::pixel(corner[0]), x_tex, y_tex};
    pos_nxt  = {s1_pos_r.x, 4'h0, s1_pos_r.y, s1_pos_r.z};
  end

  logic        out_valid_r;
  logic [15:0] out_pos_r, out_attr_r, out_tex_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_valid_r;
    end
    if (en) begin
      out_pos_r  <= pos_nxt;
      out_attr_r <= attr_nxt;
      out_tex_r  <= tex_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_word    = out_pos_r;
  assign out_attr_word   = out_attr_r;
  assign out_tex_word    = out_tex_r;
  assign out_last_vertex = out_last_r;

endmodule

// ===== src/voxel_face_cull_vertex_pack.sv =====
// ============================================================================
// voxel_face_cull_vertex_pack
// Culls the faces of one voxel against its six neighbours and emits six packed
// vertices for each face that is kept.
// ============================================================================
// Each input transaction carries one voxel: its block type, its position and
// the block types of its six neighbours. The block walks the voxel's faces in
// table order, drops a cube face whose neighbour on that side is solid (plant
// and outline faces are never dropped) and emits one output transaction per
// vertex, six per kept face, so a voxel yields 0 to 36 transactions; the last
// one carries last_vertex. A voxel with N kept faces occupies the sequencer
// for its 6*N vertices, one vertex per cycle while the output is not stalled,
// and a voxel that yields nothing (air, a fully hidden block or a code above
// outline) leaves the sequencer free. The sequencer accepts the next voxel in
// the same cycle as it issues the final vertex of the current one, so vertices
// stream without gaps. After acceptance a voxel passes the sequencer registers,
// the face-table stage and the output register. The whole pipeline holds while
// an output transaction is stalled, so nothing is lost or repeated.
// ============================================================================
module voxel_face_cull_vertex_pack (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_block_type,
  input  logic [3:0]  in_pos_x,
  input  logic [3:0]  in_pos_y,
  input  logic [3:0]  in_pos_z,
  input  logic [3:0]  in_neighbor_plus_x,
  input  logic [3:0]  in_neighbor_minus_x,
  input  logic [3:0]  in_neighbor_plus_z,
  input  logic [3:0]  in_neighbor_minus_z,
  input  logic [3:0]  in_neighbor_plus_y,
  input  logic [3:0]  in_neighbor_minus_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pos_word,
  output logic [15:0] out_attr_word,
  output logic [15:0] out_tex_word,
  output logic        out_last_vertex
);

  // Every stage advances unless a finished vertex is waiting on the output.
  logic en;
  assign en = !(out_valid && out_stall);

  // Neighbours in face order: face i is culled against entry i.
  logic [vfcv_pkg::NUM_FACES-1:0][3:0] nb;
  assign nb = {in_neighbor_minus_y, in_neighbor_plus_y, in_neighbor_minus_z,
               in_neighbor_plus_z, in_neighbor_minus_x, in_neighbor_plus_x};

  vfcv_pkg::voxel_pos_t pos;
  assign pos = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};

  vfcv_pkg::vtx_req_t req;

  vfcv_face_seq u_face_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .block_type (in_block_type),
    .pos        (pos),
    .nb         (nb),
    .req        (req)
  );

  vfcv_vertex_gen u_vertex_gen (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .req             (req),
    .out_valid       (out_valid),
    .out_pos_word    (out_pos_word),
    .out_attr_word   (out_attr_word),
    .out_tex_word    (out_tex_word),
    .out_last_vertex (out_last_vertex)
  );

endmodule
